// ----- rtl/cprs_pkg.sv -----
// ----------------------------------------------------------------------------
// cprs_pkg: shared types and constants for the cooling PWM ramp scheduler
//
// Holds the input and result item formats, the action and register index
// codes, and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package cprs_pkg;

    localparam int TEMP_W    = 16;
    localparam int DUTY_W    = 7;
    // The sum of three 16-bit phases and three times a threshold fit in 18 bits.
    localparam int SUM_W     = TEMP_W + 2;
    // 100 times an 18-bit difference fits in 25 bits.
    localparam int NUM_W     = SUM_W + DUTY_W;
    // The divisor is pre-shifted by the top quotient bit position.
    localparam int DSH_W     = SUM_W + DUTY_W - 1;
    localparam int CFG_IDX_W = 3;
    localparam int STEP_W    = 3;

    localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd100;
    localparam logic [DUTY_W-1:0] DUTY_OFF  = 7'd0;
    localparam logic [STEP_W-1:0] LAST_STEP = 3'(DUTY_W - 1);

    // Action codes of an input item.
    localparam logic [1:0] ACT_BATTERY  = 2'd0;
    localparam logic [1:0] ACT_INVERTER = 2'd1;
    localparam logic [1:0] ACT_TICK     = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_INVERTER_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INVERTER_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BATTERY_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BATTERY_HIGH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SEND_PERIOD   = 3'd4;

    typedef struct packed {
        logic [1:0]        action;
        logic [TEMP_W-1:0] temp_a;
        logic [TEMP_W-1:0] temp_b;
        logic [TEMP_W-1:0] temp_c;
    } in_item_t;

    typedef struct packed {
        logic              cooling_enable;
        logic [DUTY_W-1:0] tractive_fan_duty;
        logic [DUTY_W-1:0] tractive_pump_duty;
        logic [DUTY_W-1:0] accumulator_fan_duty;
    } out_item_t;

    typedef struct packed {
        logic load_frame;
        logic tick;
        logic classify;
        logic div_step;
        logic write_back;
    } cmd_t;

    typedef struct packed {
        logic sat;
        logic out_busy;
    } sts_t;

endpackage

// ----- rtl/cprs_ctrl.sv -----
// ----------------------------------------------------------------------------
// cprs_ctrl: sequencer for the cooling PWM ramp scheduler
//
// Accepts input items, and walks each temperature frame through the
// classify, divide and write-back steps of the datapath (no divide when saturated).
// ----------------------------------------------------------------------------
module cprs_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [1:0]           in_action,
    output logic                 in_ready,
    input  cprs_pkg::sts_t       sts,
    output cprs_pkg::cmd_t       cmd
);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_CLASSIFY,
        ST_DIVIDE,
        ST_WRITE
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic [cprs_pkg::STEP_W-1:0]     step_reg;
    logic [cprs_pkg::STEP_W-1:0]     step_next;
    logic                            accept;
    logic                            is_frame;

    // A tick may only be taken when the result register is free or drains now.
    assign in_ready = (state_reg == ST_IDLE) &&
                      ((in_action != cprs_pkg::ACT_TICK) || !sts.out_busy);
    assign accept   = in_valid && in_ready;
    assign is_frame = in_action inside {cprs_pkg::ACT_BATTERY, cprs_pkg::ACT_INVERTER};

    always_comb
    begin
        cmd.load_frame = accept && is_frame;
        cmd.tick       = accept && (in_action == cprs_pkg::ACT_TICK);
        cmd.classify   = (state_reg == ST_CLASSIFY);
        cmd.div_step   = (state_reg == ST_DIVIDE);
        cmd.write_back = (state_reg == ST_WRITE);
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_frame)
                begin
                    state_next = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY:
            begin
                step_next  = '0;
                state_next = sts.sat ? ST_WRITE : ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == cprs_pkg::LAST_STEP)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ----- rtl/cprs_dp.sv -----
// ----------------------------------------------------------------------------
// cprs_dp: datapath of the cooling PWM ramp scheduler
//
// Holds the configuration, the duty registers, the tick counter and the
// result register, and a shift-subtract divider that yields one duty bit
// per step.
// ----------------------------------------------------------------------------
module cprs_dp
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  cprs_pkg::cmd_t                      cmd,
    output cprs_pkg::sts_t                      sts,
    input  cprs_pkg::in_item_t                  in_item,
    output logic                                out_valid,
    input  logic                                out_ready,
    output cprs_pkg::out_item_t                 out_item,
    input  logic                                cfg_we,
    input  logic [cprs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cprs_pkg::TEMP_W-1:0]         cfg_data
);

    localparam int SW = cprs_pkg::SUM_W;
    localparam int DW = cprs_pkg::DUTY_W;

    logic [cprs_pkg::TEMP_W-1:0] inv_low_reg;
    logic [cprs_pkg::TEMP_W-1:0] inv_high_reg;
    logic [cprs_pkg::TEMP_W-1:0] bat_low_reg;
    logic [cprs_pkg::TEMP_W-1:0] bat_high_reg;
    logic [cprs_pkg::TEMP_W-1:0] period_reg;

    logic [DW-1:0]               fan_duty_reg;
    logic [DW-1:0]               pump_duty_reg;
    logic [DW-1:0]               accy_duty_reg;
    logic [cprs_pkg::TEMP_W-1:0] elapsed_reg;
    logic [cprs_pkg::TEMP_W-1:0] elapsed_next;
    logic                        out_valid_reg;
    cprs_pkg::out_item_t         out_item_reg;

    logic [SW-1:0]               t_reg;
    logic [SW-1:0]               lo_reg;
    logic [SW-1:0]               hi_reg;
    logic                        is_inv_reg;
    logic [cprs_pkg::NUM_W-1:0]  num_reg;
    logic [cprs_pkg::DSH_W-1:0]  dsh_reg;
    logic [DW-1:0]               quo_reg;

    logic [SW-1:0]               frame_t;
    logic [SW-1:0]               frame_lo;
    logic [SW-1:0]               frame_hi;
    logic                        frame_inv;
    logic                        above_hi;
    logic [SW-1:0]               diff;
    logic [SW-1:0]               span;
    logic [cprs_pkg::NUM_W-1:0]  scaled;
    logic                        fits;

    // Inverter frames compare the phase sum against thresholds times three.
    always_comb
    begin
        frame_inv = (in_item.action == cprs_pkg::ACT_INVERTER);
        if (frame_inv)
        begin
            frame_t  = SW'(in_item.temp_a) + SW'(in_item.temp_b) + SW'(in_item.temp_c);
            frame_lo = SW'(inv_low_reg) + {1'b0, inv_low_reg, 1'b0};
            frame_hi = SW'(inv_high_reg) + {1'b0, inv_high_reg, 1'b0};
        end
        else
        begin
            frame_t  = SW'(in_item.temp_a);
            frame_lo = SW'(bat_low_reg);
            frame_hi = SW'(bat_high_reg);
        end
    end

    // Above high saturates full; otherwise below low, or an empty window, gives zero.
    assign above_hi     = t_reg > hi_reg;
    assign sts.sat      = above_hi || (t_reg < lo_reg) || (hi_reg == lo_reg);
    assign sts.out_busy = out_valid_reg && !out_ready;
    assign diff         = t_reg - lo_reg;
    assign span         = hi_reg - lo_reg;
    assign scaled       = cprs_pkg::NUM_W'(diff) * cprs_pkg::NUM_W'(cprs_pkg::DUTY_FULL);
    assign fits         = num_reg >= cprs_pkg::NUM_W'(dsh_reg);

    always_comb
    begin
        elapsed_next = elapsed_reg;
        if (elapsed_reg != '1)
        begin
            elapsed_next = elapsed_reg + 16'd1;
        end
    end

    // Frame operands and divider registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_frame)
        begin
            t_reg      <= frame_t;
            lo_reg     <= frame_lo;
            hi_reg     <= frame_hi;
            is_inv_reg <= frame_inv;
        end
        if (cmd.classify)
        begin
            num_reg <= scaled;
            dsh_reg <= {span, {(DW-1){1'b0}}};
            quo_reg <= above_hi ? cprs_pkg::DUTY_FULL : cprs_pkg::DUTY_OFF;
        end
        else if (cmd.div_step)
        begin
            if (fits)
            begin
                num_reg <= num_reg - cprs_pkg::NUM_W'(dsh_reg);
            end
            dsh_reg <= dsh_reg >> 1;
            quo_reg <= {quo_reg[DW-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_low_reg   <= 16'd30;
            inv_high_reg  <= 16'd60;
            bat_low_reg   <= 16'd3000;
            bat_high_reg  <= 16'd5000;
            period_reg    <= 16'd500;
            fan_duty_reg  <= '0;
            pump_duty_reg <= '0;
            accy_duty_reg <= '0;
            elapsed_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    cprs_pkg::REG_INVERTER_LOW:  inv_low_reg  <= cfg_data;
                    cprs_pkg::REG_INVERTER_HIGH: inv_high_reg <= cfg_data;
                    cprs_pkg::REG_BATTERY_LOW:   bat_low_reg  <= cfg_data;
                    cprs_pkg::REG_BATTERY_HIGH:  bat_high_reg <= cfg_data;
                    cprs_pkg::REG_SEND_PERIOD:   period_reg   <= cfg_data;
                    default:                     ;
                endcase
            end
            if (cmd.write_back)
            begin
                if (is_inv_reg)
                begin
                    fan_duty_reg  <= quo_reg;
                    pump_duty_reg <= quo_reg;
                end
                else
                begin
                    accy_duty_reg <= quo_reg;
                end
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.tick)
            begin
                if (elapsed_next >= period_reg)
                begin
                    elapsed_reg   <= '0;
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    elapsed_reg <= elapsed_next;
                end
            end
        end
    end

    // Result payload: loaded only when a command is sent.
    always_ff @(posedge clk)
    begin
        if (cmd.tick && (elapsed_next >= period_reg))
        begin
            out_item_reg.cooling_enable       <= 1'b1;
            out_item_reg.tractive_fan_duty    <= fan_duty_reg;
            out_item_reg.tractive_pump_duty   <= pump_duty_reg;
            out_item_reg.accumulator_fan_duty <= accy_duty_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // A finished duty is never above full scale.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_back |-> (quo_reg <= cprs_pkg::DUTY_FULL))
        else $error("duty above full scale at write-back");

    // The divider only runs on a non-empty window.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.classify && !sts.sat) |=> (dsh_reg != '0))
        else $error("divider started with a zero divisor");

    // A command goes out only together with a restart of the tick count.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (elapsed_reg == '0))
        else $error("command sent without clearing the tick count");

endmodule

// ----- rtl/cooling_pwm_ramp_scheduler.sv -----
// ----------------------------------------------------------------------------
// cooling_pwm_ramp_scheduler: cooling duty ramps and periodic command sender
//
// Turns battery and inverter temperature frames into three cooling duties
// and sends them as one command every send_period millisecond ticks.
// ----------------------------------------------------------------------------
// A battery frame (action 0) sets the accumulator fan duty from temp_a in
// hundredths of a degree; an inverter frame (action 1) sets the tractive fan
// and pump duties, which are always equal, from the exact average of the
// three phase temperatures. A duty is 100 above the high threshold, else 0
// below the low one or when both thresholds are equal, and otherwise
// floor(100*(t-low)/(high-low)). A tick (action 2), when the saturating tick
// count reaches send_period, transfers one command out through a result
// register; action 3 is taken and ignored. A frame that lands inside its
// window occupies the block from its transfer until the next item can be
// taken: a step to classify and scale, seven steps of the shift-subtract
// divider (one duty bit each), and one to write the duty register.
// A saturated frame skips the divider.
// While a command waits in the result register, frames are still taken, and
// a tick is held off unless the command is transferred in that same cycle.
// Configuration is written through cfg_we/cfg_index/cfg_data at any edge;
// indexes beyond the register list are ignored.
module cooling_pwm_ramp_scheduler
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  cprs_pkg::in_item_t                  in_item,
    output logic                                out_valid,
    input  logic                                out_ready,
    output cprs_pkg::out_item_t                 out_item,
    input  logic                                cfg_we,
    input  logic [cprs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cprs_pkg::TEMP_W-1:0]         cfg_data
);

    // Commands from the sequencer and status back from the datapath.
    cprs_pkg::cmd_t cmd;
    cprs_pkg::sts_t sts;

    // The sequencer owns the input handshake and steps frames through.
    cprs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_action (in_item.action),
        .in_ready  (in_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // The datapath holds all configuration, duties, tick count and results.
    cprs_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
